// ===== src/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared types, request codes, sequencer phases and helpers.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int DELAY_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 4;
    localparam int REQ_W       = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam logic [DELAY_W-1:0]   SHORT_DELAY_RESET = 16'd2;
    localparam logic [DELAY_W-1:0]   LONG_DELAY_RESET  = 16'd5;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE     = 4'd8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SHORT_DELAY = 1'b0,
        CFG_LONG_DELAY  = 1'b1
    } cfg_idx_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_ACK   = 3'd3,
        REQ_NACK  = 3'd4,
        REQ_SEND  = 3'd5,
        REQ_RECV  = 3'd6
    } req_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_A     = 4'd1,
        PH_ST_B     = 4'd2,
        PH_SP_A     = 4'd3,
        PH_SP_B     = 4'd4,
        PH_AK_A     = 4'd5,
        PH_AK_B     = 4'd6,
        PH_TX_LOW   = 4'd7,
        PH_TX_HIGH  = 4'd8,
        PH_TX_ADLY  = 4'd9,
        PH_TX_AWAIT = 4'd10,
        PH_TX_TAIL  = 4'd11,
        PH_RX_LOW   = 4'd12,
        PH_RX_RISE  = 4'd13,
        PH_RX_HIGH  = 4'd14
    } phase_t;

    typedef struct packed {
        logic [DELAY_W-1:0] short_delay;
        logic [DELAY_W-1:0] long_delay;
    } cfg_t;

    // MSB first, so scl_out lands in bit 0 of tdata
    typedef struct packed {
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              busy_res;
        logic              sda_is_output;
        logic              sda_out;
        logic              scl_out;
    } res_t;

    localparam int RES_W = $bits(res_t);

    // a zero delay still lasts one tick
    function automatic logic [DELAY_W-1:0] load_wait(input logic [DELAY_W-1:0] d);
        return (d == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : d;
    endfunction

endpackage

// ===== src/i2c_bit_level_master_top.sv =====
// A request waits in the input register; when the core steps, its result is registered onto m_tdata.
// Throughput: one request per cycle while no held result waits on m_tready; the sequencer step is a single pass.
// While a held result waits on m_tready, the input register takes a request only if it is empty.
// Reset (aresetn low, synchronous): channels empty, sequencer idle,
// SCL and SDA high with SDA driven, delays back to 2 and 5 ticks.
// ----------------------------------------------------------------------------
// I2C bit-level master top
// Request register, sequencer core, result register and delay registers.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2cm_pkg::S_TDATA_W-1:0]     s_tdata,   // tx_byte[7:0], sda_in[8]
    input  logic [i2cm_pkg::REQ_W-1:0]         s_tuser,   // req_type[2:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2cm_pkg::M_TDATA_W-1:0]     m_tdata,   // scl_out[0], sda_out[1],
                                                          // sda_is_output[2], busy_res[3],
                                                          // rx_byte[11:4], rx_valid[12]
    input  logic                               cfg_we,
    input  logic [i2cm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [i2cm_pkg::DELAY_W-1:0]       cfg_wdata
);
    import i2cm_pkg::*;

    logic                 in_vld_reg;
    logic [REQ_W-1:0]     in_req_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_sda_reg;
    logic                 out_vld_reg;
    res_t                 out_res_reg;
    cfg_t                 cfg_reg;
    res_t                 core_res;
    logic                 step;

    // advance the request when the result slot is free or draining
    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= s_tuser;
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_sda_reg  <= s_tdata[BYTE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_delay <= SHORT_DELAY_RESET;
            cfg_reg.long_delay  <= LONG_DELAY_RESET;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_SHORT_DELAY: cfg_reg.short_delay <= cfg_wdata;
                CFG_LONG_DELAY:  cfg_reg.long_delay  <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    i2cm_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step),
        .req_type (in_req_reg),
        .tx_byte  (in_byte_reg),
        .sda_in   (in_sda_reg),
        .cfg      (cfg_reg),
        .res      (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_res_reg};

endmodule

// ===== src/i2cm_core.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master sequencer core
// Holds the pin and phase state and applies one request per enabled cycle.
// ----------------------------------------------------------------------------
module i2cm_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  logic [i2cm_pkg::REQ_W-1:0]     req_type,
    input  logic [i2cm_pkg::BYTE_W-1:0]    tx_byte,
    input  logic                           sda_in,
    input  i2cm_pkg::cfg_t                 cfg,
    output i2cm_pkg::res_t                 res
);
    import i2cm_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [DELAY_W-1:0]   wait_reg, wait_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 dir_reg, dir_next;
    logic [BYTE_W-1:0]    last_rx_reg, last_rx_next;
    logic                 rx_flag;
    logic                 adv;
    logic [BIT_CNT_W-1:0] bit_inc;

    always_comb begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        wait_next    = wait_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        dir_next     = dir_reg;
        last_rx_next = last_rx_reg;
        rx_flag      = 1'b0;
        adv          = 1'b0;
        bit_inc      = bit_cnt_reg + 1'b1;

        if (req_t'(req_type) == REQ_TICK) begin
            case (phase_reg)
                PH_IDLE: adv = 1'b0;
                PH_TX_AWAIT: begin
                    if (!sda_in) begin
                        scl_next   = 1'b0;
                        phase_next = PH_TX_TAIL;
                        wait_next  = load_wait(cfg.long_delay);
                    end
                end
                PH_RX_RISE: begin
                    // sample on the first tick of SCL high
                    shift_next   = {shift_reg[BYTE_W-2:0], sda_in};
                    bit_cnt_next = bit_inc;
                    phase_next   = PH_RX_HIGH;
                    if (wait_reg > 1) begin
                        wait_next = wait_reg - 1'b1;
                    end else begin
                        wait_next = '0;
                        adv       = 1'b1;
                    end
                end
                default: begin
                    if (wait_reg > 1) begin
                        wait_next = wait_reg - 1'b1;
                    end else begin
                        wait_next = '0;
                        adv       = 1'b1;
                    end
                end
            endcase
        end else if (phase_reg == PH_IDLE) begin
            case (req_t'(req_type))
                REQ_START: begin
                    bit_cnt_next = '0;
                    dir_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = PH_ST_A; wait_next = load_wait(cfg.long_delay);
                end
                REQ_STOP: begin
                    bit_cnt_next = '0;
                    dir_next = 1'b1; sda_next = 1'b0; scl_next = 1'b0;
                    phase_next = PH_SP_A; wait_next = load_wait(cfg.long_delay);
                end
                REQ_ACK: begin
                    bit_cnt_next = '0;
                    dir_next = 1'b1; sda_next = 1'b0; scl_next = 1'b0;
                    phase_next = PH_AK_A; wait_next = load_wait(cfg.short_delay);
                end
                REQ_NACK: begin
                    bit_cnt_next = '0;
                    dir_next = 1'b1; sda_next = 1'b1; scl_next = 1'b0;
                    phase_next = PH_AK_A; wait_next = load_wait(cfg.short_delay);
                end
                REQ_SEND: begin
                    bit_cnt_next = '0;
                    dir_next   = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = tx_byte[BYTE_W-1];
                    shift_next = {tx_byte[BYTE_W-2:0], 1'b0};
                    phase_next = PH_TX_LOW; wait_next = load_wait(cfg.short_delay);
                end
                REQ_RECV: begin
                    bit_cnt_next = '0;
                    dir_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0;
                    shift_next = '0;
                    phase_next = PH_RX_LOW; wait_next = load_wait(cfg.short_delay);
                end
                default: adv = 1'b0;
            endcase
        end

        if (adv) begin
            case (phase_next)
                PH_ST_A: begin
                    sda_next = 1'b0; scl_next = 1'b1;
                    phase_next = PH_ST_B; wait_next = load_wait(cfg.long_delay);
                end
                PH_ST_B: begin
                    sda_next = 1'b0; scl_next = 1'b0; phase_next = PH_IDLE;
                end
                PH_SP_A: begin
                    scl_next = 1'b1;
                    phase_next = PH_SP_B; wait_next = load_wait(cfg.long_delay);
                end
                PH_SP_B: begin
                    sda_next = 1'b1; phase_next = PH_IDLE;
                end
                PH_AK_A: begin
                    scl_next = 1'b1;
                    phase_next = PH_AK_B; wait_next = load_wait(cfg.short_delay);
                end
                PH_AK_B: begin
                    scl_next = 1'b0; phase_next = PH_IDLE;
                end
                PH_TX_LOW: begin
                    scl_next = 1'b1;
                    phase_next = PH_TX_HIGH; wait_next = load_wait(cfg.short_delay);
                end
                PH_TX_HIGH: begin
                    bit_cnt_next = bit_inc;
                    if (bit_inc < BITS_PER_BYTE) begin
                        scl_next   = 1'b0;
                        sda_next   = shift_reg[BYTE_W-1];
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        phase_next = PH_TX_LOW; wait_next = load_wait(cfg.short_delay);
                    end else begin
                        // release SDA for the slave ack
                        dir_next = 1'b0; sda_next = 1'b1; scl_next = 1'b1;
                        phase_next = PH_TX_ADLY; wait_next = load_wait(cfg.long_delay);
                    end
                end
                PH_TX_ADLY: phase_next = PH_TX_AWAIT;
                PH_TX_TAIL: phase_next = PH_IDLE;
                PH_RX_LOW: begin
                    scl_next = 1'b1;
                    phase_next = PH_RX_RISE; wait_next = load_wait(cfg.short_delay);
                end
                PH_RX_RISE, PH_RX_HIGH: begin
                    if (bit_cnt_next < BITS_PER_BYTE) begin
                        scl_next = 1'b0;
                        phase_next = PH_RX_LOW; wait_next = load_wait(cfg.short_delay);
                    end else begin
                        last_rx_next = shift_next;
                        rx_flag      = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        res.scl_out       = scl_next;
        res.sda_out       = dir_next ? sda_next : 1'b1;
        res.sda_is_output = dir_next;
        res.busy_res      = (phase_next != PH_IDLE);
        res.rx_byte       = last_rx_next;
        res.rx_valid      = rx_flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            wait_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            dir_reg     <= 1'b1;
            last_rx_reg <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            wait_reg    <= wait_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            dir_reg     <= dir_next;
            last_rx_reg <= last_rx_next;
        end
    end

endmodule

// ===== src/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// I2C bit-level master port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [i2cm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import i2cm_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a completed receive leaves the sequencer idle
    a_rx_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12] |-> !m_tdata[3])
        else $error("rx_valid while busy");

    // released SDA reads back high
    a_sda_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[1])
        else $error("sda_out low while SDA is an input");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind i2c_bit_level_master_top i2cm_checker u_i2cm_checker (.*);
